// File: hw/rtl/text_console_cell_writer_core_defines.svh
// Assertion macros for the text console cell writer.
// Included by files that assert; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define TCCW_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tccw: invariant violated");

// The condition never holds at a clock edge out of reset.
`define TCCW_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tccw: forbidden condition seen");

`endif

// File: hw/rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package tccw_pkg;

  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int IDX_W       = COL_W + ROW_W;
  localparam int POS_W       = 11;
  localparam int POS_IN_W    = 16;
  localparam int TAB_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] OP_PUT         = 3'd0;
  localparam logic [2:0] OP_READ        = 3'd1;
  localparam logic [2:0] OP_SET_POS     = 3'd2;
  localparam logic [2:0] OP_SCROLL_UP   = 3'd3;
  localparam logic [2:0] OP_SCROLL_DOWN = 3'd4;
  localparam logic [2:0] OP_CLEAR       = 3'd5;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [15:0] BLANK_CELL       = 16'h0700;
  localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;

  typedef enum logic [3:0] {
    K_NOP,
    K_PRINT,
    K_NEWLINE,
    K_BACKSPACE,
    K_TAB,
    K_READ,
    K_SET_POS,
    K_SCROLL_UP,
    K_SCROLL_DOWN,
    K_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         char_code;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } cmd_t;

  typedef struct packed {
    logic               init;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } back_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tccw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tccw_pkg for the command word type and the queue depth.
`default_nettype none

module tccw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tccw_pkg::cmd_t push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output tccw_pkg::cmd_t     head
);

  localparam int DEPTH = tccw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tccw_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: hw/rtl/tccw_front.sv
// Front end: accepts commands, classifies them and converts set-position
// indexes to column and row by reciprocal multiplication. Depends on tccw_pkg.
`default_nettype none

module tccw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [15:0] in_position,
  input  wire logic        q_full,
  input  wire logic        hold,
  output logic             q_push,
  output tccw_pkg::cmd_t   q_data
);

  localparam int     COL_W   = tccw_pkg::COL_W;
  localparam int     ROW_W   = tccw_pkg::ROW_W;
  localparam int     IN_W    = tccw_pkg::POS_IN_W;
  localparam int     SHIFT   = IN_W + $clog2(COLUMNS);
  localparam int     RECIP_W = IN_W + 2;
  localparam int     PROD_W  = IN_W + RECIP_W;
  localparam longint RECIP   =
    ((longint'(1) <<< SHIFT) + longint'(COLUMNS) - 1) / longint'(COLUMNS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic [IN_W-1:0]   pos_r, pos_nxt;
  logic [IN_W-1:0]   quo_r, quo_nxt;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [IN_W-1:0]   rem_full;
  logic [ROW_W-1:0]  sat_row;
  tccw_pkg::cmd_t    cls;

  assign busy = (state_r != F_IDLE) || q_full || hold;

  always_comb begin
    cls.kind      = tccw_pkg::K_NOP;
    cls.char_code = in_char_code;
    cls.col       = '0;
    cls.row       = '0;
    unique case (in_opcode)
      tccw_pkg::OP_PUT: begin
        unique case (in_char_code)
          tccw_pkg::CH_NEWLINE:   cls.kind = tccw_pkg::K_NEWLINE;
          tccw_pkg::CH_BACKSPACE: cls.kind = tccw_pkg::K_BACKSPACE;
          tccw_pkg::CH_RETURN:    cls.kind = tccw_pkg::K_NOP;
          tccw_pkg::CH_TAB:       cls.kind = tccw_pkg::K_TAB;
          default:                cls.kind = tccw_pkg::K_PRINT;
        endcase
      end
      tccw_pkg::OP_READ:        cls.kind = tccw_pkg::K_READ;
      tccw_pkg::OP_SET_POS:     cls.kind = tccw_pkg::K_SET_POS;
      tccw_pkg::OP_SCROLL_UP:   cls.kind = tccw_pkg::K_SCROLL_UP;
      tccw_pkg::OP_SCROLL_DOWN: cls.kind = tccw_pkg::K_SCROLL_DOWN;
      tccw_pkg::OP_CLEAR:       cls.kind = tccw_pkg::K_CLEAR;
      default:                  cls.kind = tccw_pkg::K_NOP;
    endcase
  end

  assign prod     = PROD_W'(pos_r) * PROD_W'(RECIP);
  assign prod_sh  = prod >> SHIFT;
  assign rem_full = pos_r - quo_r * IN_W'(COLUMNS);
  assign sat_row  = (quo_r > IN_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : quo_r[ROW_W-1:0];

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    quo_nxt   = quo_r;
    q_push    = 1'b0;
    q_data    = cls;
    unique case (state_r)
      F_IDLE: begin
        if (start && !busy) begin
          if (in_opcode == tccw_pkg::OP_SET_POS) begin
            pos_nxt   = in_position;
            state_nxt = F_DIV;
          end else begin
            q_push = 1'b1;
          end
        end
      end
      F_DIV: begin
        quo_nxt   = prod_sh[IN_W-1:0];
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        q_data.kind      = tccw_pkg::K_SET_POS;
        q_data.char_code = '0;
        q_data.col       = rem_full[COL_W-1:0];
        q_data.row       = sat_row;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    quo_r <= quo_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tccw_back.sv
// Back end: owns the cell store and the cursor, carries out queued commands
// and issues one result word per command. Depends on tccw_pkg.
`default_nettype none

module tccw_back #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [7:0]                 text_color,
  input  wire logic                       q_valid,
  input  wire tccw_pkg::cmd_t             q_head,
  output logic                            q_pop,
  output tccw_pkg::back_status_t          status,
  output logic                            out_strobe,
  output logic [7:0]                      out_read_char,
  output logic [tccw_pkg::POS_W-1:0]      out_cursor_pos
);

  localparam int COL_W     = tccw_pkg::COL_W;
  localparam int ROW_W     = tccw_pkg::ROW_W;
  localparam int IDX_W     = tccw_pkg::IDX_W;
  localparam int POS_W     = tccw_pkg::POS_W;
  localparam int TAB_W     = tccw_pkg::TAB_W;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int MOVE      = CELLS - COLUMNS;
  localparam int COL_LIMIT = 2 ** COL_W;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_READ = 5'b00010,
    B_TAB  = 5'b00100,
    B_COPY = 5'b01000,
    B_FILL = 5'b10000
  } back_state_t;

  logic [15:0]      mem [CELLS];
  logic [15:0]      rdata_r;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [15:0]      wdata;
  logic             we;

  back_state_t      state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [TAB_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic             tab_ret_r, tab_ret_nxt;
  logic [7:0]       res_char_r, res_char_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [AW-1:0]    dst_r, dst_nxt;
  logic [AW-1:0]    step_r, step_nxt;
  logic             asc_r, asc_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    wdst_r, wdst_nxt;
  logic [AW-1:0]    fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]    fill_end_r, fill_end_nxt;
  logic             init_r, init_nxt;
  logic             strobe_r;
  logic [7:0]       char_out_r;
  logic [POS_W-1:0] pos_out_r;

  logic [TAB_W-1:0] tab_left [COL_LIMIT];
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] nxt_idx;
  logic [IDX_W-1:0] bs_idx;
  logic [COL_W-1:0] bs_col;
  logic [ROW_W-1:0] bs_row;
  logic             at_last_col;
  logic             at_last_row;
  logic             adv_scroll;
  logic [COL_W-1:0] col_adv;
  logic [ROW_W-1:0] row_adv;
  logic             go_move;
  logic             go_asc;
  logic             fin;

  for (genvar gi = 0; gi < COL_LIMIT; gi++) begin : g_tab
    assign tab_left[gi] = TAB_W'(TAB_STOP - (gi % TAB_STOP));
  end

  assign cur_idx     = IDX_W'(row_r) * IDX_W'(COLUMNS) + IDX_W'(col_r);
  assign nxt_idx     = IDX_W'(row_nxt) * IDX_W'(COLUMNS) + IDX_W'(col_nxt);
  assign at_last_col = (col_r == COL_W'(COLUMNS - 1));
  assign at_last_row = (row_r == ROW_W'(ROWS - 1));
  assign adv_scroll  = at_last_col && at_last_row;
  assign col_adv     = at_last_col ? '0 : col_r + 1'b1;
  assign row_adv     = (at_last_col && !at_last_row) ? row_r + 1'b1 : row_r;
  assign bs_col      = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;
  assign bs_row      = (col_r == '0) ? row_r - 1'b1 : row_r;
  assign bs_idx      = IDX_W'(bs_row) * IDX_W'(COLUMNS) + IDX_W'(bs_col);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    tab_cnt_nxt   = tab_cnt_r;
    tab_ret_nxt   = tab_ret_r;
    res_char_nxt  = res_char_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    step_nxt      = step_r;
    asc_nxt       = asc_r;
    pend_nxt      = pend_r;
    wdst_nxt      = wdst_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    init_nxt      = init_r;
    raddr         = cur_idx[AW-1:0];
    we            = 1'b0;
    waddr         = cur_idx[AW-1:0];
    wdata         = tccw_pkg::BLANK_CELL;
    q_pop         = 1'b0;
    go_move       = 1'b0;
    go_asc        = 1'b1;
    fin           = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          res_char_nxt = '0;
          tab_ret_nxt  = 1'b0;
          case (q_head.kind)
            tccw_pkg::K_PRINT: begin
              we      = 1'b1;
              wdata   = {text_color, q_head.char_code};
              col_nxt = col_adv;
              row_nxt = row_adv;
              go_move = adv_scroll;
              fin     = !adv_scroll;
            end
            tccw_pkg::K_NEWLINE: begin
              we      = 1'b1;
              col_nxt = '0;
              if (at_last_row) begin
                go_move = 1'b1;
              end else begin
                row_nxt = row_r + 1'b1;
                fin     = 1'b1;
              end
            end
            tccw_pkg::K_BACKSPACE: begin
              fin = 1'b1;
              if (col_r != '0 || row_r != '0) begin
                col_nxt = bs_col;
                row_nxt = bs_row;
                we      = 1'b1;
                waddr   = bs_idx[AW-1:0];
              end
            end
            tccw_pkg::K_TAB: begin
              tab_cnt_nxt = tab_left[col_r];
              state_nxt   = B_TAB;
            end
            tccw_pkg::K_READ: begin
              state_nxt = B_READ;
            end
            tccw_pkg::K_SET_POS: begin
              col_nxt = q_head.col;
              row_nxt = q_head.row;
              fin     = 1'b1;
            end
            tccw_pkg::K_SCROLL_UP: begin
              go_move = 1'b1;
              go_asc  = 1'b0;
            end
            tccw_pkg::K_SCROLL_DOWN: begin
              row_nxt = (row_r == '0) ? '0 : row_r - 1'b1;
              go_move = 1'b1;
            end
            tccw_pkg::K_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              fill_addr_nxt = '0;
              fill_end_nxt  = AW'(CELLS - 1);
              state_nxt     = B_FILL;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      B_READ: begin
        res_char_nxt = rdata_r[7:0];
        col_nxt      = col_adv;
        row_nxt      = row_adv;
        go_move      = adv_scroll;
        fin          = !adv_scroll;
        state_nxt    = B_IDLE;
      end
      B_TAB: begin
        we          = 1'b1;
        wdata       = {text_color, tccw_pkg::CH_SPACE};
        col_nxt     = col_adv;
        row_nxt     = row_adv;
        tab_cnt_nxt = tab_cnt_r - 1'b1;
        if (adv_scroll) begin
          tab_ret_nxt = (tab_cnt_r != TAB_W'(1));
          go_move     = 1'b1;
        end else if (tab_cnt_r == TAB_W'(1)) begin
          fin       = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_COPY: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wdst_r;
          wdata = rdata_r;
        end
        if (step_r != AW'(MOVE)) begin
          raddr    = src_r;
          pend_nxt = 1'b1;
          wdst_nxt = dst_r;
          step_nxt = step_r + 1'b1;
          src_nxt  = asc_r ? src_r + 1'b1 : src_r - 1'b1;
          dst_nxt  = asc_r ? dst_r + 1'b1 : dst_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = B_FILL;
          end
        end
      end
      B_FILL: begin
        we    = 1'b1;
        waddr = fill_addr_r;
        if (fill_addr_r == fill_end_r) begin
          state_nxt = B_IDLE;
          if (init_r) begin
            init_nxt = 1'b0;
          end else if (tab_ret_r) begin
            state_nxt = B_TAB;
          end else begin
            fin = 1'b1;
          end
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (go_move) begin
      asc_nxt   = go_asc;
      step_nxt  = '0;
      pend_nxt  = 1'b0;
      state_nxt = B_COPY;
      if (go_asc) begin
        src_nxt       = AW'(COLUMNS);
        dst_nxt       = '0;
        fill_addr_nxt = AW'(MOVE);
        fill_end_nxt  = AW'(CELLS - 1);
      end else begin
        src_nxt       = AW'(MOVE - 1);
        dst_nxt       = AW'(CELLS - 1);
        fill_addr_nxt = '0;
        fill_end_nxt  = AW'(COLUMNS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_FILL;
      col_r       <= '0;
      row_r       <= '0;
      tab_ret_r   <= 1'b0;
      pend_r      <= 1'b0;
      fill_addr_r <= '0;
      fill_end_r  <= AW'(CELLS - 1);
      init_r      <= 1'b1;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      tab_ret_r   <= tab_ret_nxt;
      pend_r      <= pend_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      init_r      <= init_nxt;
      strobe_r    <= fin;
    end
  end

  always_ff @(posedge clk) begin
    tab_cnt_r  <= tab_cnt_nxt;
    res_char_r <= res_char_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    step_r     <= step_nxt;
    asc_r      <= asc_nxt;
    wdst_r     <= wdst_nxt;
    if (fin) begin
      char_out_r <= res_char_nxt;
      pos_out_r  <= nxt_idx[POS_W-1:0];
    end
  end

  assign status.init    = init_r;
  assign status.col     = col_r;
  assign status.row     = row_r;
  assign out_strobe     = strobe_r;
  assign out_read_char  = char_out_r;
  assign out_cursor_pos = pos_out_r;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cell_writer_core.sv
// Top level of the text console cell writer: front end, command queue,
// back end and the text colour register. Depends on tccw_pkg and the defines.
`default_nettype none

`include "text_console_cell_writer_core_defines.svh"

// A command word is taken at a clock edge where start is high and busy is low.
// Every command gives exactly one result word, shown for one cycle with
// out_strobe high; the receiver cannot stall it, so it must be captured then.
// After reset the cell store is blanked one cell a cycle, all COLUMNS*ROWS
// cells (2000 by default), with busy held high. A two-entry queue separates
// the front end from the back end, so busy drops again as soon as a queue
// slot is free. Put, newline, backspace, carriage return and unused codes
// finish from the idle state unless they scroll; read goes through a read
// state, since the store has a registered read port. Set position keeps the
// front end busy through its divide and push states while a reciprocal
// multiplication splits the index into row and column. Tab writes one space
// a cycle, pausing for any scroll it causes. Any scroll, either commanded or
// caused by passing the last row, moves the picture through the store's read
// and write ports one cell a cycle and then blanks a row. Clear blanks the
// whole store. text_color may be written only while no command is outstanding.
module text_console_cell_writer_core #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [7:0]            in_char_code,
  input  wire logic [15:0]           in_position,
  output logic                       out_strobe,
  output logic [7:0]                 out_read_char,
  output logic [10:0]                out_cursor_pos,
  input  wire logic                  cfg_wr_en,
  input  wire logic [7:0]            cfg_wr_data
);

  logic [7:0]             text_color_r;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_valid;
  tccw_pkg::cmd_t         q_data;
  tccw_pkg::cmd_t         q_head;
  tccw_pkg::back_status_t back_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tccw_pkg::TEXT_COLOR_RESET;
    end else if (cfg_wr_en) begin
      text_color_r <= cfg_wr_data;
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_char_code (in_char_code),
    .in_position  (in_position),
    .q_full       (q_full),
    .hold         (back_st.init),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  tccw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  tccw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_color     (text_color_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .status         (back_st),
    .out_strobe     (out_strobe),
    .out_read_char  (out_read_char),
    .out_cursor_pos (out_cursor_pos)
  );

  `TCCW_ASSERT_NEVER(a_no_word_during_init, back_st.init && out_strobe)
  `TCCW_ASSERT_NEVER(a_queue_no_overflow, q_full && q_push && !q_pop)
  `TCCW_ASSERT_ALWAYS(a_cursor_in_range, (int'(back_st.col) < COLUMNS) && (int'(back_st.row) < ROWS))

endmodule

`default_nettype wire

// File: tb/text_console_cell_writer_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the text console cell writer: watches the command, result and colour
// ports, keeps its own copy of the cell store and cursor, and compares every result word.
// Depends on tccw_pkg for the opcodes, control characters and blank cell value.
module text_console_cell_writer_core_checker #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [15:0] in_position,
  input  wire logic        out_strobe,
  input  wire logic [7:0]  out_read_char,
  input  wire logic [10:0] out_cursor_pos,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [10:0] cursor_pos;
  } console_word_t;

  logic [15:0]   cells [CELLS];
  int unsigned   col;
  int unsigned   row;
  logic [7:0]    text_color;
  console_word_t expected_words [$];

  task automatic blank_store();
    for (int i = 0; i < CELLS; i++) cells[i] = tccw_pkg::BLANK_CELL;
  endtask

  task automatic roll_picture_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = tccw_pkg::BLANK_CELL;
    if (row > 0) row--;
  endtask

  task automatic roll_picture_down();
    for (int i = CELLS - 1; i >= COLUMNS; i--) cells[i] = cells[i - COLUMNS];
    for (int i = 0; i < COLUMNS; i++) cells[i] = tccw_pkg::BLANK_CELL;
  endtask

  task automatic settle_rows();
    while (row > ROWS - 1) roll_picture_up();
  endtask

  task automatic step_cursor();
    col++;
    if (col >= COLUMNS) begin
      col = 0;
      row++;
    end
    settle_rows();
  endtask

  task automatic write_glyph(input logic [7:0] ch);
    cells[row * COLUMNS + col] = {text_color, ch};
    step_cursor();
  endtask

  task automatic put_glyph(input logic [7:0] ch);
    int unsigned fill;
    case (ch)
      tccw_pkg::CH_NEWLINE: begin
        cells[row * COLUMNS + col] = tccw_pkg::BLANK_CELL;
        col = 0;
        row++;
        settle_rows();
      end
      tccw_pkg::CH_BACKSPACE: begin
        if (col != 0 || row != 0) begin
          if (col == 0) begin
            col = COLUMNS - 1;
            row--;
          end else begin
            col--;
          end
          cells[row * COLUMNS + col] = tccw_pkg::BLANK_CELL;
        end
      end
      tccw_pkg::CH_RETURN: begin
      end
      tccw_pkg::CH_TAB: begin
        fill = TAB_STOP - (col % TAB_STOP);
        repeat (fill) write_glyph(tccw_pkg::CH_SPACE);
      end
      default: write_glyph(ch);
    endcase
  endtask

  task automatic predict_console_word(input logic [2:0] op, input logic [7:0] ch,
                                      input logic [15:0] pos, output console_word_t word);
    logic [7:0] rd;
    rd = 8'h00;
    case (op)
      tccw_pkg::OP_PUT: put_glyph(ch);
      tccw_pkg::OP_READ: begin
        rd = cells[row * COLUMNS + col][7:0];
        step_cursor();
      end
      tccw_pkg::OP_SET_POS: begin
        col = pos % COLUMNS;
        row = pos / COLUMNS;
        if (row > ROWS - 1) row = ROWS - 1;
      end
      tccw_pkg::OP_SCROLL_UP: roll_picture_down();
      tccw_pkg::OP_SCROLL_DOWN: roll_picture_up();
      tccw_pkg::OP_CLEAR: begin
        blank_store();
        col = 0;
        row = 0;
      end
      default: begin
      end
    endcase
    word.read_char  = rd;
    word.cursor_pos = 11'(row * COLUMNS + col);
  endtask

  always @(posedge clk) begin : monitor
    console_word_t want;
    if (!rst_n) begin
      blank_store();
      col        = 0;
      row        = 0;
      text_color = tccw_pkg::TEXT_COLOR_RESET;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) text_color = cfg_wr_data;
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: read_char %0h, cursor_pos %0d",
                 out_read_char, out_cursor_pos);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_read_char !== want.read_char) begin
            $error("read_char mismatch: expected %0h, actual %0h",
                   want.read_char, out_read_char);
            fail_count++;
          end
          if (out_cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos mismatch: expected %0d, actual %0d",
                   want.cursor_pos, out_cursor_pos);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_console_word(in_opcode, in_char_code, in_position, want);
        expected_words.push_back(want);
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: tb/text_console_cell_writer_core_tb.sv
`timescale 1ns / 1ps
// Top of the text console cell writer testbench: clock, reset, command and colour stimulus,
// watchdog and verdict. Depends on tccw_pkg, the block and the checker module beside it.
module text_console_cell_writer_core_tb;

  localparam int COLUMNS          = 80;
  localparam int ROWS             = 25;
  localparam int TAB_STOP         = 4;
  localparam int CELLS            = COLUMNS * ROWS;
  localparam int QUIET_LIMIT      = 20000;
  localparam int SETTLE_CYCLES    = 50;
  localparam int RANDOM_PER_PHASE = 410;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode    = tccw_pkg::OP_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [15:0] in_position  = 16'h0000;
  logic        out_strobe;
  logic [7:0]  out_read_char;
  logic [10:0] out_cursor_pos;
  logic        cfg_wr_en    = 1'b0;
  logic [7:0]  cfg_wr_data  = 8'h00;

  int fail_count;
  int pending;
  int idle_pct;
  int items_sent;
  int results_seen;
  int colour_writes;
  int phase_idle [4] = '{0, 85, 0, 21};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_cell_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_position   (in_position),
    .out_strobe    (out_strobe),
    .out_read_char (out_read_char),
    .out_cursor_pos(out_cursor_pos),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  text_console_cell_writer_core_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_position   (in_position),
    .out_strobe    (out_strobe),
    .out_read_char (out_read_char),
    .out_cursor_pos(out_cursor_pos),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe) results_seen <= results_seen + 1;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rst_n && start && !busy) || (rst_n && out_strobe)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                              input logic [15:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_position  <= pos;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_colour(input logic [7:0] colour);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= colour;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    colour_writes++;
  endtask

  function automatic logic [7:0] random_glyph();
    int r;
    r = $urandom_range(99);
    if (r < 3) return tccw_pkg::CH_NEWLINE;
    if (r < 6) return tccw_pkg::CH_BACKSPACE;
    if (r < 9) return tccw_pkg::CH_TAB;
    if (r < 11) return tccw_pkg::CH_RETURN;
    return 8'($urandom);
  endfunction

  task automatic send_noise_command();
    int         r;
    logic [2:0] op;
    logic [7:0] ch;
    logic [15:0] pos;
    r   = $urandom_range(99);
    ch  = 8'($urandom);
    pos = 16'($urandom);
    if (r < 45) begin
      op = tccw_pkg::OP_PUT;
      ch = random_glyph();
    end else if (r < 60) begin
      op = tccw_pkg::OP_READ;
    end else if (r < 78) begin
      op = tccw_pkg::OP_SET_POS;
      if ($urandom_range(1) == 0) pos = 16'($urandom_range(CELLS - 1));
    end else if (r < 82) begin
      op = tccw_pkg::OP_SCROLL_UP;
    end else if (r < 86) begin
      op = tccw_pkg::OP_SCROLL_DOWN;
    end else if (r < 88) begin
      op = tccw_pkg::OP_CLEAR;
    end else if (r < 92) begin
      op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    end else begin
      op = tccw_pkg::OP_PUT;
      ch = random_glyph();
    end
    send_command(op, ch, pos);
  endtask

  // Most of the traffic writes a short run of characters and reads it back from the
  // same anchor, so that reads see written cells rather than blank ones.
  task automatic random_phase(input int count);
    int first;
    int anchor;
    int run;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(99) < 40) begin
        anchor = $urandom_range(CELLS - 1);
        run    = $urandom_range(1, 8);
        send_command(tccw_pkg::OP_SET_POS, 8'($urandom), 16'(anchor));
        repeat (run) send_command(tccw_pkg::OP_PUT, random_glyph(), 16'($urandom));
        send_command(tccw_pkg::OP_SET_POS, 8'($urandom), 16'(anchor));
        repeat (run) send_command(tccw_pkg::OP_READ, 8'($urandom), 16'($urandom));
      end else begin
        send_noise_command();
      end
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_command(tccw_pkg::OP_READ, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_PUT, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_PUT, 8'hFF, 16'hFFFF);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_RETURN, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 16'h0000);
    send_command(tccw_pkg::OP_PUT, 8'h41, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'(COLUMNS - 1));
    send_command(tccw_pkg::OP_PUT, 8'h7A, 16'h0000);
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'hFFFF);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'(CELLS - 1));
    send_command(tccw_pkg::OP_PUT, 8'h5A, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'(CELLS - COLUMNS));
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'(CELLS - TAB_STOP));
    send_command(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 16'h0000);
    send_command(tccw_pkg::OP_SET_POS, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_READ, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_SCROLL_UP, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_SCROLL_DOWN, 8'h00, 16'h0000);
    send_command(tccw_pkg::OP_CLEAR, 8'h00, 16'h0000);
    send_command(OP_SPARE_LO, 8'hFF, 16'hFFFF);
    send_command(OP_SPARE_HI, 8'h00, 16'h0000);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_colour(8'h00);
        1: write_colour(8'hFF);
        default: write_colour(8'($urandom));
      endcase
      idle_pct = phase_idle[p];
      random_phase(RANDOM_PER_PHASE);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d console commands and compared %0d result words, over four idling",
             items_sent, results_seen);
    $display("phases and %0d text colour writes, including both extreme attributes.",
             colour_writes);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
